FILE: rtl/detector_row_packet_deframer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the row packet deframer
// Clocked implication checks, reset-qualified on the active-low reset.
// ---------------------------------------------------------------------------
`ifndef DETECTOR_ROW_PACKET_DEFRAMER_ASSERT_SVH
`define DETECTOR_ROW_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define DPRD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DPRD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/dprd_pkg.sv
// ---------------------------------------------------------------------------
// dprd_pkg
// Shared types and constants of the row packet deframer.
// ---------------------------------------------------------------------------
package dprd_pkg;

	localparam int DEF_MAX_COLUMNS = 1024;
	localparam int DEF_MAX_ROWS    = 1024;
	localparam int QUEUE_DEPTH     = 2;

	// wide enough for any clamped limit (up to 2047)
	localparam int LIM_W = 13;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;

	localparam logic [CFG_IW-1:0] REG_ROWS      = 3'd0;
	localparam logic [CFG_IW-1:0] REG_COLUMNS   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_FLUSH     = 3'd2;
	localparam logic [CFG_IW-1:0] REG_START_MRK = 3'd3;
	localparam logic [CFG_IW-1:0] REG_END_MRK   = 3'd4;

	localparam logic [10:0] RST_ROWS      = 11'd1024;
	localparam logic [10:0] RST_COLUMNS   = 11'd1024;
	localparam logic [7:0]  RST_FLUSH     = 8'd75;
	localparam logic [15:0] RST_START_MRK = 16'd35981;
	localparam logic [15:0] RST_END_MRK   = 16'd36495;

	localparam logic [3:0] TAG_TIME_HI = 4'hF;
	localparam logic [3:0] TAG_TIME_LO = 4'hE;
	localparam logic [3:0] TAG_ROW     = 4'hD;
	localparam logic [3:0] TAG_T0_HI   = 4'hC;
	localparam logic [3:0] TAG_T0_LO   = 4'hB;
	localparam logic [3:0] TAG_T1_HI   = 4'hA;
	localparam logic [3:0] TAG_T1_LO   = 4'h9;

	localparam logic [2:0] KIND_PIXEL   = 3'd0;
	localparam logic [2:0] KIND_TIME    = 3'd1;
	localparam logic [2:0] KIND_TEMP0   = 3'd2;
	localparam logic [2:0] KIND_TEMP1   = 3'd3;
	localparam logic [2:0] KIND_ROW_END = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [23:0] value;
		logic [9:0]  row;
		logic [9:0]  column;
		logic [31:0] frame;
		logic        complete;
		logic [7:0]  phase;
	} result_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

endpackage

FILE: rtl/detector_row_packet_deframer.sv
// ---------------------------------------------------------------------------
// detector_row_packet_deframer
// Parses telemetry row packets into time, temperature, pixel and row-end words.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  --------  ---------------------  -----------------------------------------
//  in        in_valid / in_ready    stream_word
//  out       out_valid / out_ready  result_kind, value, row_index,
//                                   column_index, frame_index,
//                                   frame_complete, plot_phase
//  cfg       cfg_we (no wait)       cfg_index, cfg_data
//
//  One word per cycle sustained while the queue is not full; the parser
//  decides each word in the cycle it is accepted and pushes at most one
//  result into a two-word queue. A result enters the queue at the edge that
//  takes its word and moves on into the output register when the output stage loads.
//  in_ready drops only while the queue is full, i.e. after the sink stalls.
//  Reset (arst_n low) restores the default registers and the parser state.
// ---------------------------------------------------------------------------
module detector_row_packet_deframer #(
	parameter int MAX_COLUMNS = dprd_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = dprd_pkg::DEF_MAX_ROWS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_we,
	input  logic [dprd_pkg::CFG_IW-1:0] cfg_index,
	input  logic [dprd_pkg::CFG_DW-1:0] cfg_data,
	// input words
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [15:0]                 stream_word,
	// result words
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  result_kind,
	output logic [23:0]                 value,
	output logic [9:0]                  row_index,
	output logic [9:0]                  column_index,
	output logic [31:0]                 frame_index,
	output logic                        frame_complete,
	output logic [7:0]                  plot_phase
);

	logic              take, push, pop;
	dprd_pkg::result_t push_data, head, out_data;
	dprd_pkg::q_stat_t stat;

	// front stalls only on a full queue
	assign in_ready = !stat.full;
	assign take     = in_valid && in_ready;

	dprd_front #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.word      (stream_word),
		.push      (push),
		.push_data (push_data)
	);

	dprd_fifo #(
		.DEPTH (dprd_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	dprd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.head      (head),
		.pop       (pop),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	assign result_kind    = out_data.kind;
	assign value          = out_data.value;
	assign row_index      = out_data.row;
	assign column_index   = out_data.column;
	assign frame_index    = out_data.frame;
	assign frame_complete = out_data.complete;
	assign plot_phase     = out_data.phase;

endmodule

FILE: rtl/dprd_front.sv
// ---------------------------------------------------------------------------
// dprd_front
// Config registers and packet parser; one word per cycle while take is high, at most one result.
// ---------------------------------------------------------------------------
`include "detector_row_packet_deframer_assert.svh"

module dprd_front #(
	parameter int MAX_COLUMNS = dprd_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = dprd_pkg::DEF_MAX_ROWS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dprd_pkg::CFG_IW-1:0] cfg_index,
	input  logic [dprd_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        take,
	input  logic [15:0]                 word,
	output logic                        push,
	output dprd_pkg::result_t           push_data
);

	localparam int PCW = $clog2(MAX_COLUMNS + 1);
	localparam int CRW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int LW  = dprd_pkg::LIM_W;

	typedef enum logic [3:0] {
		S_START, S_TIME_A, S_TIME_B, S_ROW,
		S_T0_A, S_T0_B, S_T1_A, S_T1_B, S_BODY
	} state_t;

	logic [10:0] rows_cfg_q, cols_cfg_q;
	logic [7:0]  flush_q;
	logic [15:0] start_mrk_q, end_mrk_q;

	state_t      state_q, state_d, st_eff;
	logic [PCW-1:0] pix_q, pix_d;
	logic [CRW-1:0] row_q, row_d;
	logic [11:0] time_hi_q, time_hi_d, t0_hi_q, t0_hi_d, t1_hi_q, t1_hi_d;
	logic [31:0] frame_q, frame_d;
	logic        armed_q, armed_d;
	logic [7:0]  phase_q, phase_d;

	logic [3:0]  tag;
	logic [11:0] low;
	logic [LW-1:0] rows_eff, cols_eff, pix_ext, row_ext;
	logic [8:0]  period, phase_inc;
	logic [7:0]  phase_nx;
	logic        last_row, emit;
	dprd_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q  <= dprd_pkg::RST_ROWS;
			cols_cfg_q  <= dprd_pkg::RST_COLUMNS;
			flush_q     <= dprd_pkg::RST_FLUSH;
			start_mrk_q <= dprd_pkg::RST_START_MRK;
			end_mrk_q   <= dprd_pkg::RST_END_MRK;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dprd_pkg::REG_ROWS:      rows_cfg_q  <= cfg_data[10:0];
				dprd_pkg::REG_COLUMNS:   cols_cfg_q  <= cfg_data[10:0];
				dprd_pkg::REG_FLUSH:     flush_q     <= cfg_data[7:0];
				dprd_pkg::REG_START_MRK: start_mrk_q <= cfg_data;
				dprd_pkg::REG_END_MRK:   end_mrk_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign tag = word[15:12];
	assign low = word[11:0];

	assign rows_eff = (LW'(rows_cfg_q) > LW'(MAX_ROWS)) ? LW'(MAX_ROWS) : LW'(rows_cfg_q);
	assign cols_eff = (LW'(cols_cfg_q) > LW'(MAX_COLUMNS)) ? LW'(MAX_COLUMNS)
		: LW'(cols_cfg_q);
	assign pix_ext  = LW'(pix_q);
	assign row_ext  = LW'(row_q);

	// pixel budget used up: straight to end search
	assign st_eff = (pix_ext >= cols_eff) ? S_BODY : state_q;

	assign last_row  = (rows_eff != '0) && (row_ext == rows_eff - LW'(1)) && armed_q;
	// period zero wraps at 256
	assign period    = (flush_q == 8'd0) ? 9'd256 : {1'b0, flush_q};
	assign phase_inc = {1'b0, phase_q} + 9'd1;
	assign phase_nx  = (phase_inc >= period) ? 8'd0 : phase_inc[7:0];

	always_comb begin
		state_d   = st_eff;
		pix_d     = pix_q;
		row_d     = row_q;
		time_hi_d = time_hi_q;
		t0_hi_d   = t0_hi_q;
		t1_hi_d   = t1_hi_q;
		frame_d   = frame_q;
		armed_d   = armed_q;
		phase_d   = phase_q;
		emit      = 1'b0;
		res          = '0;
		res.row      = row_ext[9:0];
		res.frame    = frame_q;
		unique case (st_eff)
			S_START: begin
				if (word == start_mrk_q) state_d = S_TIME_A;
			end
			S_TIME_A: begin
				if (tag == dprd_pkg::TAG_TIME_HI) begin
					time_hi_d = low;
					state_d   = S_TIME_B;
				end
			end
			S_TIME_B: begin
				if (tag == dprd_pkg::TAG_TIME_LO) begin
					state_d   = S_ROW;
					emit      = 1'b1;
					res.kind  = dprd_pkg::KIND_TIME;
					res.value = {time_hi_q, low};
				end
			end
			S_ROW: begin
				if (tag == dprd_pkg::TAG_ROW && LW'(low) < rows_eff) begin
					row_d   = CRW'(low);
					state_d = S_T0_A;
					pix_d   = '0;
					if (low == 12'd0) begin
						frame_d = frame_q + 32'd1;
						armed_d = 1'b1;
					end
				end
			end
			S_T0_A: begin
				if (tag == dprd_pkg::TAG_T0_HI) begin
					t0_hi_d = low;
					state_d = S_T0_B;
				end
			end
			S_T0_B: begin
				if (tag == dprd_pkg::TAG_T0_LO) begin
					state_d   = S_T1_A;
					emit      = 1'b1;
					res.kind  = dprd_pkg::KIND_TEMP0;
					res.value = {t0_hi_q, low};
				end
			end
			S_T1_A: begin
				if (tag == dprd_pkg::TAG_T1_HI) begin
					t1_hi_d = low;
					state_d = S_T1_B;
				end
			end
			S_T1_B: begin
				if (tag == dprd_pkg::TAG_T1_LO) begin
					state_d   = S_BODY;
					emit      = 1'b1;
					res.kind  = dprd_pkg::KIND_TEMP1;
					res.value = {t1_hi_q, low};
				end
			end
			S_BODY: begin
				if (pix_ext < cols_eff) begin
					// pixels are taken unchecked, end marker included
					emit       = 1'b1;
					res.kind   = dprd_pkg::KIND_PIXEL;
					res.value  = {8'd0, word};
					res.column = pix_ext[9:0];
					pix_d      = pix_q + PCW'(1);
				end else if (word == end_mrk_q) begin
					pix_d    = '0;
					state_d  = S_START;
					emit     = 1'b1;
					res.kind = dprd_pkg::KIND_ROW_END;
					if (last_row) begin
						phase_d      = phase_nx;
						armed_d      = 1'b0;
						res.complete = 1'b1;
						res.phase    = phase_nx;
					end
				end
			end
			default: state_d = S_START;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_START;
			pix_q     <= '0;
			row_q     <= '0;
			time_hi_q <= '0;
			t0_hi_q   <= '0;
			t1_hi_q   <= '0;
			frame_q   <= '0;
			armed_q   <= 1'b0;
			phase_q   <= '0;
		end else if (take) begin
			state_q   <= state_d;
			pix_q     <= pix_d;
			row_q     <= row_d;
			time_hi_q <= time_hi_d;
			t0_hi_q   <= t0_hi_d;
			t1_hi_q   <= t1_hi_d;
			frame_q   <= frame_d;
			armed_q   <= armed_d;
			phase_q   <= phase_d;
		end
	end

	assign push      = take & emit;
	assign push_data = res;

	`DPRD_ASSERT_IMP(a_cmpl_row_end, clk, arst_n, push && push_data.complete, push_data.kind == dprd_pkg::KIND_ROW_END, "frame complete on a non row-end result")
	`DPRD_ASSERT_IMP(a_col_pixel_only, clk, arst_n, push && push_data.kind != dprd_pkg::KIND_PIXEL, push_data.column == 10'd0, "column set on a non-pixel result")
	`DPRD_ASSERT_NXT(a_frame_hold, clk, arst_n, !take, $stable(frame_q), "frame count moved without a word")

endmodule

FILE: rtl/dprd_fifo.sv
// ---------------------------------------------------------------------------
// dprd_fifo
// Short result queue between parser and output stage.
// ---------------------------------------------------------------------------
`include "detector_row_packet_deframer_assert.svh"

module dprd_fifo #(
	parameter int DEPTH = dprd_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dprd_pkg::result_t push_data,
	input  logic              pop,
	output dprd_pkg::result_t head,
	output dprd_pkg::q_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dprd_pkg::result_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)      cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	assign head          = mem_q[rd_ptr_q];
	assign stat.full     = (cnt_q == CW'(DEPTH));
	assign stat.nonempty = (cnt_q != '0);

	`DPRD_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH), "queue count past depth")
	`DPRD_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !stat.full || pop, "push into full queue")
	`DPRD_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, stat.nonempty, "pop from empty queue")

endmodule

FILE: rtl/dprd_back.sv
// ---------------------------------------------------------------------------
// dprd_back
// Output register; drains the queue whenever the register is empty or the sink takes a word.
// ---------------------------------------------------------------------------
module dprd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dprd_pkg::q_stat_t stat,
	input  dprd_pkg::result_t head,
	output logic              pop,
	input  logic              out_ready,
	output logic              out_valid,
	output dprd_pkg::result_t out_data
);

	logic              vld_q;
	dprd_pkg::result_t data_q;
	logic              load;

	assign load = !vld_q || out_ready;
	assign pop  = load && stat.nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= stat.nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) data_q <= head;
	end

	assign out_valid = vld_q;
	assign out_data  = data_q;

endmodule

FILE: sim/tb_detector_row_packet_deframer.sv
// ---------------------------------------------------------------------------
// tb_detector_row_packet_deframer
// Self-checking bench for the row packet deframer. Telemetry words are fed
// through a valid/ready driver, every accepted word is run through a local
// parser model, and each result word is compared field by field against the
// oldest predicted result. Runs a directed opening, one full-width packet and
// then randomized packet streams under a series of limit/marker values.
// ---------------------------------------------------------------------------
module tb_detector_row_packet_deframer;

	// parser phases of the local model
	typedef enum logic [3:0] {
		ST_HUNT, ST_TIME_HI, ST_TIME_LO, ST_ROW,
		ST_T0_HI, ST_T0_LO, ST_T1_HI, ST_T1_LO, ST_BODY
	} parse_t;

	// how a generated row packet is shaped
	typedef enum int {PKT_CLEAN, PKT_NOISY, PKT_CUT, PKT_JUNK} pkt_shape_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [dprd_pkg::CFG_IW-1:0]  cfg_index = '0;
	logic [dprd_pkg::CFG_DW-1:0]  cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [15:0]                  stream_word = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [2:0]                   result_kind;
	logic [23:0]                  value;
	logic [9:0]                   row_index;
	logic [9:0]                   column_index;
	logic [31:0]                  frame_index;
	logic                         frame_complete;
	logic [7:0]                   plot_phase;

	detector_row_packet_deframer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.stream_word   (stream_word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.value         (value),
		.row_index     (row_index),
		.column_index  (column_index),
		.frame_index   (frame_index),
		.frame_complete(frame_complete),
		.plot_phase    (plot_phase)
	);

	always #5 clk = ~clk;

	// words waiting to be driven, results waiting to be seen
	logic [15:0]       telemetry_words [$];
	dprd_pkg::result_t predicted_results [$];

	int error_count = 0;
	int word_total = 0;
	bit no_idle = 1'b0;     // both sides run without gaps or stalls
	bit in_taken = 1'b0;    // word accepted at the last rising edge
	bit out_taken = 1'b0;   // result accepted at the last rising edge
	int lead_gap = 0;
	int hold_off = 0;

	// model copy of the control registers (reset values)
	logic [10:0] rows_lim = dprd_pkg::RST_ROWS;
	logic [10:0] cols_lim = dprd_pkg::RST_COLUMNS;
	logic [7:0]  flush_lim = dprd_pkg::RST_FLUSH;
	logic [15:0] open_mark = dprd_pkg::RST_START_MRK;
	logic [15:0] close_mark = dprd_pkg::RST_END_MRK;

	// model copy of the parser state
	parse_t      pstate = ST_HUNT;
	int unsigned pixels_taken = 0;
	logic [9:0]  held_row = '0;
	logic [11:0] time_msb = '0;
	logic [11:0] temp0_msb = '0;
	logic [11:0] temp1_msb = '0;
	logic [31:0] frames_seen = '0;
	bit          frame_open = 1'b0;
	logic [7:0]  flush_phase = '0;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	// every result carries the held row and the frame count as they stand
	function automatic void post_result(logic [2:0] kind, logic [23:0] val,
			logic [9:0] col, logic done, logic [7:0] ph);
		dprd_pkg::result_t r;
		r.kind     = kind;
		r.value    = val;
		r.row      = held_row;
		r.column   = col;
		r.frame    = frames_seen;
		r.complete = done;
		r.phase    = ph;
		predicted_results.push_back(r);
	endfunction

	function automatic void deframe_word(logic [15:0] w);
		logic [3:0]  tag;
		logic [11:0] low;
		int unsigned rows_eff;
		int unsigned cols_eff;
		int unsigned period;
		int unsigned nxt;
		tag = w[15:12];
		low = w[11:0];
		rows_eff = (rows_lim > dprd_pkg::DEF_MAX_ROWS) ? dprd_pkg::DEF_MAX_ROWS : rows_lim;
		cols_eff = (cols_lim > dprd_pkg::DEF_MAX_COLUMNS) ? dprd_pkg::DEF_MAX_COLUMNS
			: cols_lim;

		// column limit reached (or lowered under us): straight to end search
		if (pixels_taken >= cols_eff)
			pstate = ST_BODY;

		case (pstate)
			ST_HUNT: begin
				if (w == open_mark)
					pstate = ST_TIME_HI;
			end
			ST_TIME_HI: begin
				if (tag == dprd_pkg::TAG_TIME_HI) begin
					time_msb = low;
					pstate = ST_TIME_LO;
				end
			end
			ST_TIME_LO: begin
				// row field still holds the previous packet's row here
				if (tag == dprd_pkg::TAG_TIME_LO) begin
					pstate = ST_ROW;
					post_result(dprd_pkg::KIND_TIME, {time_msb, low}, '0, 1'b0, '0);
				end
			end
			ST_ROW: begin
				if (tag == dprd_pkg::TAG_ROW && low < rows_eff) begin
					held_row = low[9:0];
					if (low == 0) begin
						frames_seen = frames_seen + 1;
						frame_open = 1'b1;
					end
					pstate = ST_T0_HI;
					pixels_taken = 0;
				end
			end
			ST_T0_HI: begin
				if (tag == dprd_pkg::TAG_T0_HI) begin
					temp0_msb = low;
					pstate = ST_T0_LO;
				end
			end
			ST_T0_LO: begin
				if (tag == dprd_pkg::TAG_T0_LO) begin
					pstate = ST_T1_HI;
					post_result(dprd_pkg::KIND_TEMP0, {temp0_msb, low}, '0, 1'b0, '0);
				end
			end
			ST_T1_HI: begin
				if (tag == dprd_pkg::TAG_T1_HI) begin
					temp1_msb = low;
					pstate = ST_T1_LO;
				end
			end
			ST_T1_LO: begin
				if (tag == dprd_pkg::TAG_T1_LO) begin
					pstate = ST_BODY;
					post_result(dprd_pkg::KIND_TEMP1, {temp1_msb, low}, '0, 1'b0, '0);
				end
			end
			default: begin
				// pixels are taken blind, end marker included
				if (pixels_taken < cols_eff) begin
					post_result(dprd_pkg::KIND_PIXEL, {8'h00, w}, 10'(pixels_taken),
						1'b0, '0);
					pixels_taken = pixels_taken + 1;
				end else if (w == close_mark) begin
					pixels_taken = 0;
					pstate = ST_HUNT;
					if (rows_eff != 0 && held_row == rows_eff - 1 && frame_open) begin
						// period 0 means wrap at 256; a phase past the period folds to 0
						period = (flush_lim == 0) ? 256 : flush_lim;
						nxt = flush_phase + 1;
						if (nxt >= period)
							nxt = 0;
						flush_phase = 8'(nxt);
						frame_open = 1'b0;
						post_result(dprd_pkg::KIND_ROW_END, '0, '0, 1'b1, flush_phase);
					end else begin
						post_result(dprd_pkg::KIND_ROW_END, '0, '0, 1'b0, '0);
					end
				end
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	task automatic log_mismatch(string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	task automatic check_result();
		dprd_pkg::result_t want;
		if (predicted_results.size() == 0) begin
			log_mismatch($sformatf("unexpected result kind %0d value %h",
				result_kind, value));
		end else begin
			want = predicted_results.pop_front();
			check_field("result_kind", result_kind, want.kind);
			check_field("value", value, want.value);
			check_field("row_index", row_index, want.row);
			check_field("column_index", column_index, want.column);
			check_field("frame_index", frame_index, want.frame);
			check_field("frame_complete", frame_complete, want.complete);
			check_field("plot_phase", plot_phase, want.phase);
		end
	endtask

	// monitor: sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			out_taken <= out_valid && out_ready;
			if (in_valid && in_ready)
				deframe_word(stream_word);
			if (out_valid && out_ready)
				check_result();
		end
	end

	// ------------------------------------------------------------------
	// driver: one word per handshake, random lead gap between words
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (lead_gap > 0) begin
				in_valid <= 1'b0;
				lead_gap = lead_gap - 1;
			end else if (telemetry_words.size() != 0) begin
				stream_word <= telemetry_words.pop_front();
				in_valid <= 1'b1;
				lead_gap = no_idle ? 0 : $urandom_range(0, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// sink: fresh random stall after each result word
	always @(negedge clk) begin
		if (out_taken)
			hold_off = no_idle ? 0 : $urandom_range(0, 3);
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off = hold_off - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// register writes (only while the parser is idle)
	// ------------------------------------------------------------------
	task automatic write_reg(logic [dprd_pkg::CFG_IW-1:0] idx,
			logic [dprd_pkg::CFG_DW-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			dprd_pkg::REG_ROWS:      rows_lim = data[10:0];
			dprd_pkg::REG_COLUMNS:   cols_lim = data[10:0];
			dprd_pkg::REG_FLUSH:     flush_lim = data[7:0];
			dprd_pkg::REG_START_MRK: open_mark = data;
			dprd_pkg::REG_END_MRK:   close_mark = data;
			default: ;
		endcase
	endtask

	task automatic program_limits(logic [10:0] rows, logic [10:0] cols,
			logic [7:0] period, logic [15:0] smark, logic [15:0] emark);
		write_reg(dprd_pkg::REG_ROWS, 16'(rows));
		write_reg(dprd_pkg::REG_COLUMNS, 16'(cols));
		write_reg(dprd_pkg::REG_FLUSH, 16'(period));
		write_reg(dprd_pkg::REG_START_MRK, smark);
		write_reg(dprd_pkg::REG_END_MRK, emark);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// stimulus builders
	// ------------------------------------------------------------------
	function automatic void add_word(logic [15:0] w);
		telemetry_words.push_back(w);
		word_total++;
	endfunction

	function automatic pkt_shape_t pick_shape();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 14)
			return PKT_CLEAN;
		if (roll < 17)
			return PKT_NOISY;
		if (roll < 19)
			return PKT_CUT;
		return PKT_JUNK;
	endfunction

	// one row packet: marker, time, row, temperatures, pixels, end marker (junk shape: random words only)
	function automatic void add_row_packet(int row, pkt_shape_t shape);
		logic [15:0] words [$];
		int cols_eff;
		int cut;
		if (shape == PKT_JUNK) begin
			repeat ($urandom_range(1, 6))
				add_word(16'($urandom));
			return;
		end
		cols_eff = (cols_lim > dprd_pkg::DEF_MAX_COLUMNS) ? dprd_pkg::DEF_MAX_COLUMNS
			: cols_lim;
		// now and then a row number that may be out of range
		if ($urandom_range(0, 9) == 0)
			row = $urandom_range(0, 4095);
		words.push_back(open_mark);
		words.push_back({dprd_pkg::TAG_TIME_HI, 12'($urandom)});
		words.push_back({dprd_pkg::TAG_TIME_LO, 12'($urandom)});
		words.push_back({dprd_pkg::TAG_ROW, 12'(row)});
		words.push_back({dprd_pkg::TAG_T0_HI, 12'($urandom)});
		words.push_back({dprd_pkg::TAG_T0_LO, 12'($urandom)});
		words.push_back({dprd_pkg::TAG_T1_HI, 12'($urandom)});
		words.push_back({dprd_pkg::TAG_T1_LO, 12'($urandom)});
		// pixels sometimes look like the end marker
		for (int i = 0; i < cols_eff; i++)
			words.push_back(($urandom_range(0, 7) == 0) ? close_mark : 16'($urandom));
		words.push_back(close_mark);
		cut = words.size();
		if (shape == PKT_CUT)
			cut = $urandom_range(1, words.size() - 1);
		for (int i = 0; i < cut; i++) begin
			if (shape == PKT_NOISY && $urandom_range(0, 3) == 0)
				add_word(16'($urandom));
			add_word(words[i]);
		end
	endfunction

	// one or two frames; deep row counts only get their first and last row
	function automatic void fill_frames();
		int rows_eff;
		rows_eff = (rows_lim > dprd_pkg::DEF_MAX_ROWS) ? dprd_pkg::DEF_MAX_ROWS : rows_lim;
		repeat ($urandom_range(1, 2)) begin
			if (rows_eff == 0 || rows_eff > 6) begin
				add_row_packet(0, pick_shape());
				add_row_packet((rows_eff == 0) ? $urandom_range(0, 3) : rows_eff - 1,
					pick_shape());
			end else begin
				for (int r = 0; r < rows_eff; r++)
					add_row_packet(r, pick_shape());
			end
		end
	endfunction

	// wait for the driver to empty, then for every predicted result,
	// then idle clocks for words that produce nothing
	task automatic drain_results();
		int waited;
		while (telemetry_words.size() != 0 || in_valid)
			@(negedge clk);
		waited = 0;
		while (predicted_results.size() != 0 && waited < 2000) begin
			@(negedge clk);
			waited++;
		end
		if (predicted_results.size() != 0) begin
			log_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
			predicted_results.delete();
		end
		repeat (8) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [15:0] opening [28];
		logic [10:0] rows_v;
		logic [10:0] cols_v;
		logic [7:0]  per_v;
		logic [15:0] sm_v;
		logic [15:0] em_v;
		int          phase_idx;

		// two rows of three pixels: noise, wrong tags, a row out of range,
		// payload extremes, end marker inside the pixels, stale row on time
		opening = '{16'h0000, dprd_pkg::RST_START_MRK, 16'hE123, 16'hF000, 16'hEFFF,
			16'hD002, 16'hD000, 16'hCFFF, 16'hB000, 16'hAABC, 16'h9DEF,
			16'hFFFF, dprd_pkg::RST_END_MRK, 16'h0000, 16'h1234, dprd_pkg::RST_END_MRK,
			dprd_pkg::RST_START_MRK, 16'hFFFF, 16'hE000, 16'hD001, 16'hC000, 16'hBFFF,
			16'hA000, 16'h9FFF, 16'h8000, 16'h7FFF, 16'h5555, dprd_pkg::RST_END_MRK};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		program_limits(11'd2, 11'd3, 8'd2, dprd_pkg::RST_START_MRK, dprd_pkg::RST_END_MRK);
		@(posedge clk);
		foreach (opening[i])
			add_word(opening[i]);
		drain_results();

		// column count above the clamp: one packet of full width
		program_limits(11'd1, 11'd2047, 8'd75, dprd_pkg::RST_START_MRK,
			dprd_pkg::RST_END_MRK);
		@(posedge clk);
		add_row_packet(0, PKT_CLEAN);
		drain_results();

		phase_idx = 0;
		while (word_total < 2000) begin
			sm_v = dprd_pkg::RST_START_MRK;
			em_v = dprd_pkg::RST_END_MRK;
			case (phase_idx)
				0: begin
					rows_v = 11'd2047; cols_v = 11'd1; per_v = 8'd255;
					sm_v = 16'h0000; em_v = 16'hFFFF;
				end
				1: begin
					// no rows and no columns at all
					rows_v = 11'd0; cols_v = 11'd0; per_v = 8'd0;
				end
				2: begin
					// phase now sits past the new period
					rows_v = 11'd1024; cols_v = 11'd2; per_v = 8'd1;
				end
				3: begin
					rows_v = 11'd1; cols_v = 11'd4; per_v = 8'd0;
				end
				4: begin
					rows_v = 11'd3; cols_v = 11'd0; per_v = 8'd3;
					sm_v = 16'hFFFF; em_v = 16'h0000;
				end
				default: begin
					case ($urandom_range(0, 11))
						0:       rows_v = 11'd0;
						1:       rows_v = 11'(1024 + $urandom_range(0, 1023));
						default: rows_v = 11'($urandom_range(1, 5));
					endcase
					cols_v = ($urandom_range(0, 11) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
					case ($urandom_range(0, 9))
						0:       per_v = 8'd0;
						1:       per_v = 8'd255;
						default: per_v = 8'($urandom_range(1, 6));
					endcase
					if ($urandom_range(0, 3) == 0) begin
						sm_v = 16'($urandom);
						em_v = 16'($urandom);
					end
				end
			endcase
			program_limits(rows_v, cols_v, per_v, sm_v, em_v);

			// two bursts per setup; the sender stops between them until
			// every predicted result has come back
			repeat (2) begin
				@(posedge clk);
				no_idle = ($urandom_range(0, 3) == 0);
				fill_frames();
				drain_results();
			end
			phase_idx++;
		end

		no_idle = 1'b0;
		drain_results();
		if (error_count == 0)
			$display("[detector_row_packet_deframer] OK");
		else
			$display("[detector_row_packet_deframer] ERROR");
		$finish;
	end

	// hang guard
	initial begin
		#5_000_000;
		$display("[detector_row_packet_deframer] ERROR");
		$finish;
	end

endmodule
